[hdl/double_ended_queue_defines.svh]
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge outside reset.
`define DEQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("deque assertion failed");
// Check that a condition never holds outside reset.
`define DEQ_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("deque forbidden condition seen");
`else
`define DEQ_ASSERT(lbl, clk, rst, prop)
`define DEQ_NEVER(lbl, clk, rst, expr)
`endif

`endif

[hdl/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CMD_W         = 3;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_LIST       = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK        = 2'd0,
      RSP_UNDERFLOW = 2'd1,
      RSP_OVERFLOW  = 2'd2,
      RSP_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_LIST
   } fsm_state_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_PUSH_FRONT,
      DP_PUSH_REAR,
      DP_POP_FRONT,
      DP_POP_REAR,
      DP_LIST_START,
      DP_LIST_NEXT,
      DP_LIST_HOLD
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       rsp_load;
      logic       rsp_from_mem;
      status_type rsp_status;
      logic       rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic list_last;
      logic out_free;
   } dp_stat_type;

endpackage

[hdl/double_ended_queue.sv]
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values in a DEPTH-slot ring.
// Request channel (req_*): one beat carries a command and a value:
//   push front, push rear, pop front, pop rear or list.
// Response channel (rsp_*): tdata is the popped or listed value (zero for
//   pushes and errors), tuser the status (ok, underflow, overflow, empty
//   list), tlast marks the final beat of one request.
// Every push and pop gives one beat; a list gives one beat per stored entry
//   from front to rear, or a single empty-status beat. Unknown commands
//   are taken and give no beat.
// Timing: a push answer goes straight into the output register; a pop
//   passes the registered read port of the ring store, then that register;
//   a list streams its entries the same way, one per cycle while rsp_tready
//   is high. Throughput: one push per cycle while rsp_tready is high; a pop
//   blocks the request side in S_POP, a list until its last beat is loaded.
// Reset empties the queue at once; the store content is not cleared.
// A stall on rsp_tready holds the output register and blocks req_tready;
//   a list in progress freezes its position until the beat is taken.
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [deq_pkg::REQ_DATA_W-1:0]     req_tdata,  // cmd[2:0], value[34:3], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [deq_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // data[31:0]
   output logic [deq_pkg::STATUS_W-1:0]       rsp_tuser,  // status[1:0]
   output logic                               rsp_tlast
);
   import deq_pkg::*;

   logic [CMD_W-1:0]          req_cmd;
   logic signed [VALUE_W-1:0] req_value;
   dp_cmd_type                dp_cmd;
   dp_stat_type               dp_stat;

   // Unpack the request beat
   assign req_cmd   = req_tdata[CMD_W-1:0];
   assign req_value = req_tdata[CMD_W+VALUE_W-1:CMD_W];

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_cmd),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .push_value (req_value),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hdl/deq_datapath.sv]
`timescale 1ns / 1ps
`include "double_ended_queue_defines.svh"

module deq_datapath #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
   input  deq_pkg::dp_cmd_type                 dp_cmd,
   output deq_pkg::dp_stat_type                dp_stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [deq_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // data[31:0]
   output logic [deq_pkg::STATUS_W-1:0]        rsp_tuser,  // status[1:0]
   output logic                                rsp_tlast
);
   import deq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [VALUE_W-1:0]  mem_ff [DEPTH];
   logic [VALUE_W-1:0]  rd_data_ff;
   logic [IW-1:0]       front_ff, front_in;
   logic [CW-1:0]       occ_ff, occ_in;
   logic [IW-1:0]       cursor_ff, cursor_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_data_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;
   logic [IW-1:0]       front_dec, front_inc;
   logic [CW-1:0]       occ_dec;
   logic [IW-1:0]       rd_addr, wr_addr;
   logic                wr_en;
   logic                out_free;

   // Ring offset: both operands below DEPTH, so one compare and subtract
   function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [IW-1:0] b);
      logic [IW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
      return s[IW-1:0];
   endfunction

   assign front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - IW'(1);
   assign front_inc = (front_ff == IW'(DEPTH - 1)) ? '0 : front_ff + IW'(1);
   assign occ_dec   = occ_ff - CW'(1);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Status back to the controller
   assign dp_stat.full      = (occ_ff == CW'(DEPTH));
   assign dp_stat.empty     = (occ_ff == '0);
   assign dp_stat.list_last = ((CW'(cursor_ff) + CW'(1)) == occ_ff);
   assign dp_stat.out_free  = out_free;

   // Select ring addresses and pointer updates per operation
   always_comb begin
      front_in  = front_ff;
      occ_in    = occ_ff;
      cursor_in = cursor_ff;
      rd_addr   = front_ff;
      wr_addr   = front_ff;
      wr_en     = 1'b0;
      case (dp_cmd.op)
         DP_PUSH_FRONT: begin
            wr_en    = 1'b1;
            wr_addr  = front_dec;
            front_in = front_dec;
            occ_in   = occ_ff + CW'(1);
         end
         DP_PUSH_REAR: begin
            wr_en   = 1'b1;
            wr_addr = wrap_add(front_ff, occ_ff[IW-1:0]);
            occ_in  = occ_ff + CW'(1);
         end
         DP_POP_FRONT: begin
            rd_addr  = front_ff;
            front_in = front_inc;
            occ_in   = occ_dec;
         end
         DP_POP_REAR: begin
            rd_addr = wrap_add(front_ff, occ_dec[IW-1:0]);
            occ_in  = occ_dec;
         end
         DP_LIST_START: begin
            rd_addr   = front_ff;
            cursor_in = '0;
         end
         DP_LIST_NEXT: begin
            rd_addr   = wrap_add(front_ff, cursor_ff + IW'(1));
            cursor_in = cursor_ff + IW'(1);
         end
         DP_LIST_HOLD: begin
            rd_addr = wrap_add(front_ff, cursor_ff);
         end
         default: begin
            rd_addr = front_ff;
         end
      endcase
   end

   // Hold valid until the beat is taken, then reload or drop
   always_comb begin
      if (dp_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Ring store with registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= push_value;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // Pointers and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         occ_ff       <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (dp_cmd.rsp_load) begin
         rsp_data_ff   <= dp_cmd.rsp_from_mem ? rd_data_ff : '0;
         rsp_status_ff <= dp_cmd.rsp_status;
         rsp_last_ff   <= dp_cmd.rsp_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `DEQ_ASSERT(a_occ_bound, clock, reset, occ_ff <= CW'(DEPTH))
   `DEQ_ASSERT(a_front_bound, clock, reset, front_ff <= IW'(DEPTH - 1))
   `DEQ_NEVER(a_push_full, clock, reset,
      (dp_cmd.op == DP_PUSH_FRONT || dp_cmd.op == DP_PUSH_REAR) && occ_ff == CW'(DEPTH))
   `DEQ_ASSERT(a_load_free, clock, reset, dp_cmd.rsp_load |-> out_free)

endmodule

[hdl/deq_ctrl.sv]
`timescale 1ns / 1ps
`include "double_ended_queue_defines.svh"

module deq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [deq_pkg::CMD_W-1:0]  req_cmd,
   input  deq_pkg::dp_stat_type       dp_stat,
   output deq_pkg::dp_cmd_type        dp_cmd
);
   import deq_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          accept;

   assign accept = req_tvalid && req_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && dp_stat.out_free) begin
               case (cmd_type'(req_cmd))
                  CMD_POP_FRONT, CMD_POP_REAR: begin
                     if (!dp_stat.empty) state_in = S_POP;
                  end
                  CMD_LIST: begin
                     if (!dp_stat.empty) state_in = S_LIST;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_POP: state_in = S_IDLE;
         S_LIST: begin
            if (dp_stat.out_free && dp_stat.list_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      req_tready          = 1'b0;
      dp_cmd.op           = DP_NOP;
      dp_cmd.rsp_load     = 1'b0;
      dp_cmd.rsp_from_mem = 1'b0;
      dp_cmd.rsp_status   = RSP_OK;
      dp_cmd.rsp_last     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_tready = dp_stat.out_free;
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                     dp_cmd.rsp_load = 1'b1;
                     if (dp_stat.full) begin
                        dp_cmd.rsp_status = RSP_OVERFLOW;
                     end else if (cmd_type'(req_cmd) == CMD_PUSH_FRONT) begin
                        dp_cmd.op = DP_PUSH_FRONT;
                     end else begin
                        dp_cmd.op = DP_PUSH_REAR;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_REAR: begin
                     if (dp_stat.empty) begin
                        dp_cmd.rsp_load   = 1'b1;
                        dp_cmd.rsp_status = RSP_UNDERFLOW;
                     end else if (cmd_type'(req_cmd) == CMD_POP_FRONT) begin
                        dp_cmd.op = DP_POP_FRONT;
                     end else begin
                        dp_cmd.op = DP_POP_REAR;
                     end
                  end
                  CMD_LIST: begin
                     if (dp_stat.empty) begin
                        dp_cmd.rsp_load   = 1'b1;
                        dp_cmd.rsp_status = RSP_EMPTY;
                     end else begin
                        dp_cmd.op = DP_LIST_START;
                     end
                  end
                  default: dp_cmd.op = DP_NOP;
               endcase
            end
         end
         S_POP: begin
            // read data of the popped slot is ready now
            dp_cmd.rsp_load     = 1'b1;
            dp_cmd.rsp_from_mem = 1'b1;
         end
         S_LIST: begin
            if (dp_stat.out_free) begin
               dp_cmd.rsp_load     = 1'b1;
               dp_cmd.rsp_from_mem = 1'b1;
               dp_cmd.rsp_last     = dp_stat.list_last;
               dp_cmd.op           = dp_stat.list_last ? DP_NOP : DP_LIST_NEXT;
            end else begin
               dp_cmd.op = DP_LIST_HOLD;
            end
         end
         default: dp_cmd.op = DP_NOP;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DEQ_ASSERT(a_accept_idle, clock, reset, req_tready |-> state_ff == S_IDLE)
   `DEQ_ASSERT(a_pop_one, clock, reset, state_ff == S_POP |=> state_ff == S_IDLE)
   `DEQ_NEVER(a_list_empty, clock, reset, state_ff == S_LIST && dp_stat.empty)
   `DEQ_ASSERT(a_pop_free, clock, reset, state_ff == S_POP |-> dp_stat.out_free)

endmodule
